FILE: hdl/fklqm_pkg.sv
// Shared types and constants for the key lock queue manager.
package fklqm_pkg;

    localparam int TXN_W    = 6;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 2;
    localparam int WAIT_W   = 7;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 7'd127;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_QUEUE_FULL = 2'd2,
        ST_UNKNOWN    = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        KIND_LOCK    = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef struct packed {
        logic             kind;
        logic [TXN_W-1:0] txn_id;
        logic [TAG_W-1:0] key_tag;
        logic             key_local;
        logic             last_key;
    } req_t;

    typedef struct packed {
        logic                ready_valid;
        logic [TXN_W-1:0]    ready_txn;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_QRD,
        S_QCHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WAIT_RD,
        S_WAIT_WR,
        S_LAST_RD,
        S_LAST_CHK,
        S_CLEAR,
        S_OUT
    } state_t;

endpackage

FILE: hdl/fifo_key_lock_queue_manager_core.sv
// Top level of the key lock queue manager: sequencer around three memories.
//
//  channel | signals             | direction | payload
//  --------+---------------------+-----------+---------------------------------
//  req     | req_valid/req_stall | in        | fklqm_pkg::req_t (kind .. last)
//  rsp     | rsp_valid/rsp_stall | out       | fklqm_pkg::rsp_t (ready, status)
//
// One item at a time. Every local item first scans the key table one entry a cycle
// through its single read port. A local lock then works through its queue and
// wait-count steps before its result is shown, a non-local lock only checks the
// wait count and a non-local release goes straight to its result. A release
// searches its queue slot by slot from the head, moves each slot behind the
// removed one forward, closes the shift and, when it removes the head of a longer queue, grants the next request.
// After reset a clearing pass zeroes the queue lengths and wait counts; no item
// is taken meanwhile.
// The result sits in an output register; while rsp_stall holds it, no new item
// is taken, and the block returns to idle once it is accepted.
module fifo_key_lock_queue_manager_core #(
    parameter int KEY_ENTRIES = 64,
    parameter int QUEUE_DEPTH = 16,
    parameter int TXN_COUNT   = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  fklqm_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output fklqm_pkg::rsp_t   rsp
);

    localparam int KE_W  = $clog2(KEY_ENTRIES);
    localparam int QD_W  = $clog2(QUEUE_DEPTH);
    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TX_W  = $clog2(TXN_COUNT);
    localparam int QA_W  = KE_W + QD_W;
    localparam int CLR_N = (KEY_ENTRIES > TXN_COUNT) ? KEY_ENTRIES : TXN_COUNT;
    localparam int CLR_W = $clog2(CLR_N + 1);
    localparam int SC_W  = $clog2(KEY_ENTRIES + 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(QUEUE_DEPTH);

    fklqm_pkg::state_t state_reg, state_next;

    // Latched request and working registers.
    fklqm_pkg::req_t   item_reg, item_next;
    logic [SC_W-1:0]   scan_reg, scan_next;       // entry whose read is in flight
    logic              hit_reg, hit_next;
    logic [KE_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [LEN_W-1:0]  hit_len_reg, hit_len_next;
    logic              free_reg, free_next;
    logic [KE_W-1:0]   free_idx_reg, free_idx_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;         // queue slot index
    logic              at_head_reg, at_head_next;
    logic [TX_W-1:0]   widx_reg, widx_next;       // wait counter being changed
    logic [fklqm_pkg::TXN_W-1:0] gtxn_reg, gtxn_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    fklqm_pkg::rsp_t   rsp_reg, rsp_next;

    // Memory ports.
    logic              km_we;
    logic [KE_W-1:0]   km_waddr, km_raddr;
    logic [KEY_BITS-1:0] km_wtag, km_rtag;
    logic [LEN_W-1:0]  km_wlen, km_rlen;
    logic              qm_we;
    logic [QA_W-1:0]   qm_waddr, qm_raddr;
    logic [fklqm_pkg::TXN_W-1:0] qm_wdata, qm_rdata;
    logic              wm_we;
    logic [TX_W-1:0]   wm_waddr, wm_raddr;
    logic [fklqm_pkg::WAIT_W-1:0] wm_wdata, wm_rdata;

    logic [KEY_BITS-1:0] tag_cmp;
    logic [KE_W-1:0]     ent;
    logic                take;

    // A transaction id folds onto the wait counters through a constant table.
    function automatic logic [TX_W-1:0] txn_index(input logic [fklqm_pkg::TXN_W-1:0] t);
        logic [TX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < (1 << fklqm_pkg::TXN_W); i++)
        begin
            if (t == fklqm_pkg::TXN_W'(i))
            begin
                idx = TX_W'(i % TXN_COUNT);
            end
        end
        return idx;
    endfunction

    assign tag_cmp = KEY_BITS'(item_reg.key_tag);
    assign ent     = hit_reg ? hit_idx_reg : free_idx_reg;
    assign take    = req_valid && !req_stall;

    fklqm_key_mem #(.KEY_ENTRIES(KEY_ENTRIES), .KEY_BITS(KEY_BITS), .LEN_W(LEN_W)) u_key (
        .clk(clk), .we(km_we), .waddr(km_waddr), .wtag(km_wtag), .wlen(km_wlen),
        .raddr(km_raddr), .rtag(km_rtag), .rlen(km_rlen)
    );

    // Each key owns a power-of-two block of slots, addressed as {entry, slot}.
    fklqm_queue_mem #(.DEPTH(2 ** QA_W)) u_queue (
        .clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(qm_wdata),
        .raddr(qm_raddr), .rdata(qm_rdata)
    );

    fklqm_wait_mem #(.TXN_COUNT(TXN_COUNT)) u_wait (
        .clk(clk), .we(wm_we), .waddr(wm_waddr), .wdata(wm_wdata),
        .raddr(wm_raddr), .rdata(wm_rdata)
    );

    assign req_stall = (state_reg != fklqm_pkg::S_IDLE);
    assign rsp_valid = (state_reg == fklqm_pkg::S_OUT);
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fklqm_pkg::S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scan_reg     <= scan_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_len_reg  <= hit_len_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        pos_reg      <= pos_next;
        at_head_reg  <= at_head_next;
        widx_reg     <= widx_next;
        gtxn_reg     <= gtxn_next;
        rsp_reg      <= rsp_next;
    end

    // Next state and datapath registers.
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        scan_next     = scan_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_len_next  = hit_len_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        pos_next      = pos_reg;
        at_head_next  = at_head_reg;
        widx_next     = widx_reg;
        gtxn_next     = gtxn_reg;
        clr_next      = clr_reg;
        rsp_next      = rsp_reg;
        unique case (state_reg)
            fklqm_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = fklqm_pkg::S_IDLE;
                end
            end
            fklqm_pkg::S_IDLE:
            begin
                if (take)
                begin
                    item_next  = req;
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    pos_next   = '0;
                    widx_next  = txn_index(req.txn_id);
                    rsp_next   = '0;
                    if (req.key_local)
                    begin
                        state_next = fklqm_pkg::S_SCAN;
                    end
                    else if (req.kind == fklqm_pkg::KIND_LOCK)
                    begin
                        state_next = fklqm_pkg::S_LAST_RD;
                    end
                    else
                    begin
                        state_next = fklqm_pkg::S_OUT;
                    end
                end
            end
            fklqm_pkg::S_SCAN:
            begin
                // Data of entry scan_reg-1 is on the read port once scan_reg > 0.
                if (scan_reg != '0)
                begin
                    if (km_rlen != '0 && km_rtag == tag_cmp && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = KE_W'(scan_reg - 1'b1);
                        hit_len_next = km_rlen;
                    end
                    if (km_rlen == '0 && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = KE_W'(scan_reg - 1'b1);
                    end
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SC_W'(KEY_ENTRIES))
                begin
                    state_next = fklqm_pkg::S_QRD;
                end
            end
            fklqm_pkg::S_QRD:
            begin
                if (item_reg.kind == fklqm_pkg::KIND_LOCK)
                begin
                    if (!hit_reg && !free_reg)
                    begin
                        rsp_next.status = fklqm_pkg::ST_TABLE_FULL;
                        state_next      = fklqm_pkg::S_LAST_RD;
                    end
                    else if (!hit_reg)
                    begin
                        hit_len_next = '0;
                        state_next   = fklqm_pkg::S_WAIT_RD;
                    end
                    else
                    begin
                        pos_next   = hit_len_reg - 1'b1;
                        state_next = fklqm_pkg::S_QCHK;
                    end
                end
                else if (!hit_reg)
                begin
                    rsp_next.status = fklqm_pkg::ST_UNKNOWN;
                    state_next      = fklqm_pkg::S_OUT;
                end
                else
                begin
                    // Slot pos_reg is being read; the search starts at the head.
                    state_next = fklqm_pkg::S_QCHK;
                end
            end
            fklqm_pkg::S_QCHK:
            begin
                if (item_reg.kind == fklqm_pkg::KIND_LOCK)
                begin
                    if (qm_rdata == item_reg.txn_id)
                    begin
                        state_next = fklqm_pkg::S_LAST_RD;
                    end
                    else if (hit_len_reg == LEN_FULL)
                    begin
                        rsp_next.status = fklqm_pkg::ST_QUEUE_FULL;
                        state_next      = fklqm_pkg::S_LAST_RD;
                    end
                    else
                    begin
                        state_next = fklqm_pkg::S_WAIT_RD;
                    end
                end
                else if (qm_rdata == item_reg.txn_id)
                begin
                    at_head_next = (pos_reg == '0);
                    state_next   = fklqm_pkg::S_SHIFT_RD;
                end
                else if (pos_reg + 1'b1 >= hit_len_reg)
                begin
                    state_next = fklqm_pkg::S_OUT;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = fklqm_pkg::S_QRD;
                end
            end
            fklqm_pkg::S_SHIFT_RD:
            begin
                // Read slot pos+1 if it exists, else finish the length update.
                if (pos_reg + 1'b1 >= hit_len_reg)
                begin
                    state_next = (at_head_reg && hit_len_reg > LEN_W'(1))
                               ? fklqm_pkg::S_WAIT_RD : fklqm_pkg::S_OUT;
                end
                else
                begin
                    state_next = fklqm_pkg::S_SHIFT_WR;
                end
            end
            fklqm_pkg::S_SHIFT_WR:
            begin
                if (at_head_reg && pos_reg == '0)
                begin
                    gtxn_next = qm_rdata;
                    widx_next = txn_index(qm_rdata);
                end
                pos_next   = pos_reg + 1'b1;
                state_next = fklqm_pkg::S_SHIFT_RD;
            end
            fklqm_pkg::S_WAIT_RD:
            begin
                state_next = fklqm_pkg::S_WAIT_WR;
            end
            fklqm_pkg::S_WAIT_WR:
            begin
                if (item_reg.kind == fklqm_pkg::KIND_LOCK)
                begin
                    state_next = fklqm_pkg::S_LAST_RD;
                end
                else
                begin
                    if (wm_rdata == fklqm_pkg::WAIT_W'(1))
                    begin
                        rsp_next.ready_valid = 1'b1;
                        rsp_next.ready_txn   = gtxn_reg;
                    end
                    state_next = fklqm_pkg::S_OUT;
                end
            end
            fklqm_pkg::S_LAST_RD:
            begin
                widx_next  = txn_index(item_reg.txn_id);
                state_next = fklqm_pkg::S_LAST_CHK;
            end
            fklqm_pkg::S_LAST_CHK:
            begin
                if (item_reg.last_key && wm_rdata == '0)
                begin
                    rsp_next.ready_valid = 1'b1;
                    rsp_next.ready_txn   = item_reg.txn_id;
                end
                state_next = fklqm_pkg::S_OUT;
            end
            fklqm_pkg::S_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = fklqm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fklqm_pkg::S_IDLE;
            end
        endcase
    end

    // Memory controls.
    always_comb
    begin
        km_we    = 1'b0;
        km_waddr = ent;
        km_wtag  = tag_cmp;
        km_wlen  = hit_len_reg;
        km_raddr = KE_W'(scan_reg);
        qm_we    = 1'b0;
        qm_waddr = {ent, QD_W'(pos_reg)};
        qm_wdata = item_reg.txn_id;
        qm_raddr = {ent, QD_W'(pos_reg)};
        wm_we    = 1'b0;
        wm_waddr = widx_reg;
        wm_wdata = wm_rdata;
        wm_raddr = widx_reg;
        unique case (state_reg)
            fklqm_pkg::S_CLEAR:
            begin
                km_waddr = KE_W'(clr_reg);
                km_wlen  = '0;
                km_we    = (clr_reg < CLR_W'(KEY_ENTRIES));
                wm_waddr = TX_W'(clr_reg);
                wm_wdata = '0;
                wm_we    = (clr_reg < CLR_W'(TXN_COUNT));
            end
            fklqm_pkg::S_QRD:
            begin
                qm_raddr = {ent, QD_W'((item_reg.kind == fklqm_pkg::KIND_LOCK)
                                       ? hit_len_reg - 1'b1 : pos_reg)};
            end
            fklqm_pkg::S_QCHK:
            begin
                // Append on a lock that is neither the tail nor full.
                if (item_reg.kind == fklqm_pkg::KIND_LOCK && qm_rdata != item_reg.txn_id
                    && hit_len_reg != LEN_FULL)
                begin
                    qm_we    = 1'b1;
                    qm_waddr = {ent, QD_W'(hit_len_reg)};
                end
            end
            fklqm_pkg::S_SHIFT_RD:
            begin
                qm_raddr = {ent, QD_W'(pos_reg + 1'b1)};
                if (pos_reg + 1'b1 >= hit_len_reg)
                begin
                    km_we   = 1'b1;
                    km_wlen = hit_len_reg - 1'b1;
                end
            end
            fklqm_pkg::S_SHIFT_WR:
            begin
                qm_we    = 1'b1;
                qm_wdata = qm_rdata;
            end
            fklqm_pkg::S_WAIT_RD:
            begin
                // A fresh or grown lock queue: write its new length and tag.
                if (item_reg.kind == fklqm_pkg::KIND_LOCK)
                begin
                    km_we   = 1'b1;
                    km_wlen = hit_len_reg + 1'b1;
                    if (!hit_reg)
                    begin
                        qm_we    = 1'b1;
                        qm_waddr = {ent, QD_W'(0)};
                    end
                end
            end
            fklqm_pkg::S_WAIT_WR:
            begin
                if (item_reg.kind == fklqm_pkg::KIND_LOCK)
                begin
                    wm_we    = (hit_len_reg != '0) && (wm_rdata != fklqm_pkg::WAIT_MAX);
                    wm_wdata = wm_rdata + 1'b1;
                end
                else
                begin
                    wm_we    = (wm_rdata != '0);
                    wm_wdata = wm_rdata - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hdl/fklqm_wait_mem.sv
// Per-transaction wait counters held in a synchronous memory; the core clears them after reset.
module fklqm_wait_mem #(
    parameter int TXN_COUNT = 64
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(TXN_COUNT)-1:0] waddr,
    input  logic [fklqm_pkg::WAIT_W-1:0] wdata,
    input  logic [$clog2(TXN_COUNT)-1:0] raddr,
    output logic [fklqm_pkg::WAIT_W-1:0] rdata
);

    logic [fklqm_pkg::WAIT_W-1:0] mem [TXN_COUNT];
    logic [fklqm_pkg::WAIT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/fklqm_queue_mem.sv
// FIFO contents of all keys in one synchronous memory.
module fklqm_queue_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [fklqm_pkg::TXN_W-1:0]   wdata,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [fklqm_pkg::TXN_W-1:0]   rdata
);

    logic [fklqm_pkg::TXN_W-1:0] mem [DEPTH];
    logic [fklqm_pkg::TXN_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/fklqm_key_mem.sv
// Key tag and queue length table in one synchronous memory, scanned one entry a cycle.
module fklqm_key_mem #(
    parameter int KEY_ENTRIES = 64,
    parameter int KEY_BITS    = 32,
    parameter int LEN_W       = 5
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(KEY_ENTRIES)-1:0] waddr,
    input  logic [KEY_BITS-1:0]            wtag,
    input  logic [LEN_W-1:0]               wlen,
    input  logic [$clog2(KEY_ENTRIES)-1:0] raddr,
    output logic [KEY_BITS-1:0]            rtag,
    output logic [LEN_W-1:0]               rlen
);

    logic [KEY_BITS+LEN_W-1:0] mem [KEY_ENTRIES];
    logic [KEY_BITS+LEN_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wtag, wlen};
        end
        rdata_reg <= mem[raddr];
    end

    assign rtag = rdata_reg[KEY_BITS+LEN_W-1:LEN_W];
    assign rlen = rdata_reg[LEN_W-1:0];

endmodule

FILE: hdl/fklqm_checker.sv
// Port-level checker for the key lock queue manager, bound to the top level.
module fklqm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input fklqm_pkg::rsp_t rsp
);

    // An accepted item always yields a result later, never in the same cycle.
    a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> !rsp_valid)
        else $error("result shown while an item is taken");

    a_one_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("input open while a result waits");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

    a_ready_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ready_valid) |-> (rsp.ready_txn == '0))
        else $error("ready_txn set without ready_valid");

endmodule

bind fifo_key_lock_queue_manager_core fklqm_checker u_fklqm_checker (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
